// ----- hw/rtl/tiie_pkg.sv -----
// ----------------------------------------------------------------------------
// Toy ISA instruction executor: shared package
// Field widths, request, opcode and class codes, pipeline payload types and
// the operand-select helper used by both the front end and the execute stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tiie_pkg;

  // Fixed field widths of the transaction payloads.
  localparam int REQ_TYPE_W = 2;
  localparam int INSTR_W    = 16;
  localparam int BYTE_W     = 8;
  localparam int REG_NUM_W  = 4;
  localparam int CLASS_W    = 3;

  // Default sizes of the machine.
  localparam int DEF_REG_COUNT = 16;
  localparam int DEF_MEM_BYTES = 256;
  localparam int DEF_PC_BITS   = 8;

  // Request types carried by an input transaction.
  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_EXEC     = 2'd0,
    REQ_LOAD_REG = 2'd1,
    REQ_LOAD_MEM = 2'd2
  } req_e;

  // Instruction opcodes; the remaining codes are illegal.
  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_INC   = 4'd3,
    OP_AND   = 4'd4,
    OP_OR    = 4'd5,
    OP_NOT   = 4'd6,
    OP_XOR   = 4'd7,
    OP_LOAD  = 4'd8,
    OP_STORE = 4'd9,
    OP_JMP   = 4'd10,
    OP_BEQZ  = 4'd11,
    OP_HLT   = 4'd15
  } op_e;

  // Instruction class reported with each result.
  typedef enum logic [CLASS_W-1:0] {
    CLS_ARITH = 3'd0,
    CLS_LOGIC = 3'd1,
    CLS_DATA  = 3'd2,
    CLS_CTRL  = 3'd3,
    CLS_HALT  = 3'd4,
    CLS_NONE  = 3'd5
  } cls_e;

  // Request held in the execute stage register.
  typedef struct packed {
    logic [REQ_TYPE_W-1:0] req_type;
    logic [INSTR_W-1:0]    instr;
    logic [BYTE_W-1:0]     paddr;
    logic [BYTE_W-1:0]     pval;
  } s1_t;

  // Result stage payload: reported fields plus the deferred state writes.
  typedef struct packed {
    logic [BYTE_W-1:0]    next_pc;
    logic                 branch_taken;
    logic                 halted;
    logic                 illegal_op;
    cls_e                 instr_class;
    logic                 reg_write;
    logic [REG_NUM_W-1:0] reg_number;
    logic [BYTE_W-1:0]    reg_value;
    logic                 mem_write;
    logic [BYTE_W-1:0]    mem_address;
    logic [BYTE_W-1:0]    mem_value;
    logic                 is_load;
    logic                 rf_we;
    logic [REG_NUM_W-1:0] rf_waddr;
    logic [BYTE_W-1:0]    rf_wdata;
    logic                 dm_we;
    logic [BYTE_W-1:0]    dm_addr;
    logic [BYTE_W-1:0]    dm_wdata;
  } s2_t;

  // Register read on the second operand port: INC, STORE and BEQZ read the
  // destination field, every other instruction reads the third field.
  function automatic logic [REG_NUM_W-1:0] opb_field(input logic [INSTR_W-1:0] instr);
    logic [3:0] op;
    op = instr[15:12];
    if (op == OP_INC || op == OP_STORE || op == OP_BEQZ) begin
      return instr[11:8];
    end
    return instr[3:0];
  endfunction

endpackage

// ----- hw/rtl/tiie_req_if.sv -----
// ----------------------------------------------------------------------------
// Toy ISA instruction executor: request channel
// Valid/ready channel that carries one execute or preload request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tiie_req_if import tiie_pkg::*; ();

  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [INSTR_W-1:0]    instr_word;
  logic [BYTE_W-1:0]     preload_addr;
  logic [BYTE_W-1:0]     preload_value;

  modport source (
    output valid, req_type, instr_word, preload_addr, preload_value,
    input  ready
  );

  modport sink (
    input  valid, req_type, instr_word, preload_addr, preload_value,
    output ready
  );

endinterface

// ----- hw/rtl/tiie_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Toy ISA instruction executor: result channel
// Valid/ready channel that carries the result of one request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tiie_rsp_if import tiie_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic [BYTE_W-1:0]        next_pc;
  logic                     branch_taken;
  logic                     halted;
  logic                     illegal_op;
  logic [CLASS_W-1:0]       instr_class;
  logic                     reg_write;
  logic [REG_NUM_W-1:0]     reg_number;
  logic signed [BYTE_W-1:0] reg_value;
  logic                     mem_write;
  logic [BYTE_W-1:0]        mem_address;
  logic [BYTE_W-1:0]        mem_value;

  modport source (
    output valid, next_pc, branch_taken, halted, illegal_op, instr_class,
           reg_write, reg_number, reg_value, mem_write, mem_address, mem_value,
    input  ready
  );

  modport sink (
    input  valid, next_pc, branch_taken, halted, illegal_op, instr_class,
           reg_write, reg_number, reg_value, mem_write, mem_address, mem_value,
    output ready
  );

endinterface

// ----- hw/rtl/tiie_ram.sv -----
// ----------------------------------------------------------------------------
// Toy ISA instruction executor: generic RAM
// One write port, one read port with registered read data. A read of the
// address written at the same edge returns the new data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tiie_ram import tiie_pkg::*; #(
  parameter int DATA_W = BYTE_W,
  parameter int DEPTH  = DEF_MEM_BYTES,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Storage array.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, write data passed through on an address match.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/tiie_regfile.sv -----
// ----------------------------------------------------------------------------
// Toy ISA instruction executor: register file
// Two registered read ports built from two RAM copies that share one write
// port. Per-register valid bits make unwritten and absent registers read zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tiie_regfile import tiie_pkg::*; #(
  parameter int REG_COUNT = DEF_REG_COUNT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [REG_NUM_W-1:0] rd_num_a_i,
  input  logic [REG_NUM_W-1:0] rd_num_b_i,
  input  logic                 wr_en_i,
  input  logic [REG_NUM_W-1:0] wr_num_i,
  input  logic [BYTE_W-1:0]    wr_data_i,
  output logic [BYTE_W-1:0]    rd_data_a_o,
  output logic [BYTE_W-1:0]    rd_data_b_o
);

  localparam int RA_W = $clog2(REG_COUNT);

  logic [REG_COUNT-1:0] vld_q;
  logic                 hit_a_q, hit_b_q;
  logic                 range_a, range_b;
  logic [RA_W-1:0]      idx_a, idx_b, idx_w;
  logic [BYTE_W-1:0]    ram_a, ram_b;

  assign idx_a   = rd_num_a_i[RA_W-1:0];
  assign idx_b   = rd_num_b_i[RA_W-1:0];
  assign idx_w   = wr_num_i[RA_W-1:0];
  assign range_a = 32'(rd_num_a_i) < REG_COUNT;
  assign range_b = 32'(rd_num_b_i) < REG_COUNT;

  // Valid bits: set on the first write, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      hit_a_q <= 1'b0;
      hit_b_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[idx_w] <= 1'b1;
      end
      if (rd_en_i) begin
        hit_a_q <= range_a && (vld_q[idx_a] || (wr_en_i && (wr_num_i == rd_num_a_i)));
        hit_b_q <= range_b && (vld_q[idx_b] || (wr_en_i && (wr_num_i == rd_num_b_i)));
      end
    end
  end

  // One RAM copy per read port.
  tiie_ram #(
    .DATA_W (BYTE_W),
    .DEPTH  (REG_COUNT)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (wr_en_i),
    .waddr_i (idx_w),
    .wdata_i (wr_data_i),
    .re_i    (rd_en_i),
    .raddr_i (idx_a),
    .rdata_o (ram_a)
  );

  tiie_ram #(
    .DATA_W (BYTE_W),
    .DEPTH  (REG_COUNT)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (wr_en_i),
    .waddr_i (idx_w),
    .wdata_i (wr_data_i),
    .re_i    (rd_en_i),
    .raddr_i (idx_b),
    .rdata_o (ram_b)
  );

  assign rd_data_a_o = hit_a_q ? ram_a : '0;
  assign rd_data_b_o = hit_b_q ? ram_b : '0;

endmodule

// ----- hw/rtl/tiie_exec.sv -----
// ----------------------------------------------------------------------------
// Toy ISA instruction executor: execute stage
// Decodes the held request, runs the ALU, forms memory addresses and the next
// program counter, and builds the result stage payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tiie_exec import tiie_pkg::*; #(
  parameter int REG_COUNT = DEF_REG_COUNT,
  parameter int MEM_BYTES = DEF_MEM_BYTES,
  parameter int PC_BITS   = DEF_PC_BITS
) (
  input  s1_t               s1_i,
  input  logic [BYTE_W-1:0] opa_i,
  input  logic [BYTE_W-1:0] opb_i,
  input  logic [PC_BITS-1:0] pc_i,
  input  logic              halt_i,
  output s2_t               res_o,
  output logic [PC_BITS-1:0] pc_o,
  output logic              halt_o
);

  localparam int PCX = (PC_BITS > 8) ? PC_BITS : 8;

  // Reduce an 8-bit address modulo the memory size by conditional subtraction.
  function automatic logic [BYTE_W-1:0] mem_wrap(input logic [BYTE_W-1:0] x);
    logic [12:0] r;
    r = 13'(x);
    for (int k = 4; k >= 0; k--) begin
      if (r >= (13'(MEM_BYTES) << k)) begin
        r = r - (13'(MEM_BYTES) << k);
      end
    end
    return r[BYTE_W-1:0];
  endfunction

  logic [3:0]           op;
  logic [3:0]           f1;
  logic [3:0]           f3;
  logic                 dest_ok;
  logic [BYTE_W-1:0]    mem_idx;
  logic [2*BYTE_W-1:0]  prod;
  logic [BYTE_W-1:0]    off8;
  logic [PCX-1:0]       pc_ext, pc_inc_x, pc_br_x;
  logic [PC_BITS-1:0]   pc_seq, pc_br;
  logic                 wr_reg;
  logic [BYTE_W-1:0]    val;
  logic                 taken;

  assign op      = s1_i.instr[15:12];
  assign f1      = s1_i.instr[11:8];
  assign f3      = s1_i.instr[3:0];
  assign dest_ok = 32'(f1) < REG_COUNT;
  assign mem_idx = mem_wrap(opa_i + 8'($signed(f3)));
  assign prod    = opa_i * opb_i;

  // Sequential and branch targets.
  assign off8     = (op == OP_JMP) ? s1_i.instr[11:4] : s1_i.instr[7:0];
  assign pc_ext   = PCX'(pc_i);
  assign pc_inc_x = pc_ext + PCX'(1);
  assign pc_br_x  = pc_inc_x + PCX'($signed(off8));
  assign pc_seq   = pc_inc_x[PC_BITS-1:0];
  assign pc_br    = pc_br_x[PC_BITS-1:0];

  // Request decode and execution.
  always_comb begin
    res_o             = '0;
    res_o.instr_class = CLS_NONE;
    pc_o              = pc_i;
    halt_o            = halt_i;
    wr_reg            = 1'b0;
    val               = '0;
    taken             = 1'b0;
    unique case (s1_i.req_type)
      REQ_EXEC: begin
        if (!halt_i) begin
          pc_o = pc_seq;
          unique case (op)
            OP_ADD: begin
              res_o.instr_class = CLS_ARITH;
              wr_reg            = 1'b1;
              val               = opa_i + opb_i;
            end
            OP_SUB: begin
              res_o.instr_class = CLS_ARITH;
              wr_reg            = 1'b1;
              val               = opa_i - opb_i;
            end
            OP_MUL: begin
              res_o.instr_class = CLS_ARITH;
              wr_reg            = 1'b1;
              val               = prod[BYTE_W-1:0];
            end
            OP_INC: begin
              res_o.instr_class = CLS_ARITH;
              wr_reg            = 1'b1;
              val               = opb_i + 8'd1;
            end
            OP_AND: begin
              res_o.instr_class = CLS_LOGIC;
              wr_reg            = 1'b1;
              val               = opa_i & opb_i;
            end
            OP_OR: begin
              res_o.instr_class = CLS_LOGIC;
              wr_reg            = 1'b1;
              val               = opa_i | opb_i;
            end
            OP_NOT: begin
              res_o.instr_class = CLS_LOGIC;
              wr_reg            = 1'b1;
              val               = ~opa_i;
            end
            OP_XOR: begin
              res_o.instr_class = CLS_LOGIC;
              wr_reg            = 1'b1;
              val               = opa_i ^ opb_i;
            end
            OP_LOAD: begin
              // The loaded byte arrives from the data memory in the result stage.
              res_o.instr_class = CLS_DATA;
              wr_reg            = 1'b1;
              res_o.is_load     = 1'b1;
              res_o.dm_addr     = mem_idx;
              res_o.mem_address = mem_idx;
            end
            OP_STORE: begin
              res_o.instr_class = CLS_DATA;
              res_o.dm_we       = 1'b1;
              res_o.dm_addr     = mem_idx;
              res_o.dm_wdata    = opb_i;
              res_o.mem_write   = 1'b1;
              res_o.mem_address = mem_idx;
              res_o.mem_value   = opb_i;
            end
            OP_JMP: begin
              res_o.instr_class = CLS_CTRL;
              taken             = 1'b1;
              pc_o              = pc_br;
            end
            OP_BEQZ: begin
              res_o.instr_class = CLS_CTRL;
              if (opb_i == '0) begin
                taken = 1'b1;
                pc_o  = pc_br;
              end
            end
            OP_HLT: begin
              res_o.instr_class = CLS_HALT;
              halt_o            = 1'b1;
              pc_o              = pc_i;
            end
            default: begin
              res_o.illegal_op = 1'b1;
            end
          endcase
          if (wr_reg && dest_ok) begin
            res_o.rf_we      = 1'b1;
            res_o.rf_waddr   = f1;
            res_o.rf_wdata   = val;
            res_o.reg_write  = 1'b1;
            res_o.reg_number = f1;
            res_o.reg_value  = val;
          end
        end
      end
      REQ_LOAD_REG: begin
        res_o.rf_we    = 32'(s1_i.paddr) < REG_COUNT;
        res_o.rf_waddr = s1_i.paddr[REG_NUM_W-1:0];
        res_o.rf_wdata = s1_i.pval;
      end
      REQ_LOAD_MEM: begin
        res_o.dm_we    = 32'(s1_i.paddr) < MEM_BYTES;
        res_o.dm_addr  = s1_i.paddr;
        res_o.dm_wdata = s1_i.pval;
      end
      default: begin
        // Unknown request types change nothing.
      end
    endcase
    res_o.next_pc      = BYTE_W'(pc_o);
    res_o.halted       = halt_o;
    res_o.branch_taken = taken;
  end

endmodule

// ----- hw/rtl/toy_isa_instruction_executor_unit.sv -----
// ----------------------------------------------------------------------------
// Toy ISA instruction executor unit
// A request is held in the execute stage register and then in the result stage
// register, whose contents form the result transaction.
// Throughput: one transaction per cycle while the result channel is ready; the
// register file is read at acceptance and the data memory as an item advances.
// Reset clears the pipeline, the program counter, the halt flag and the
// register file valid bits; the data memory is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module toy_isa_instruction_executor_unit import tiie_pkg::*; #(
  parameter int REG_COUNT = DEF_REG_COUNT,
  parameter int MEM_BYTES = DEF_MEM_BYTES,
  parameter int PC_BITS   = DEF_PC_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tiie_req_if.sink  req_i,
  tiie_rsp_if.source rsp_o
);

  localparam int MA_W = $clog2(MEM_BYTES);

  logic               s1_valid_q, s2_valid_q;
  s1_t                s1_q;
  s2_t                s2_q, exe_res;
  logic [PC_BITS-1:0] pc_q, pc_d;
  logic               halt_q, halt_d;
  logic               s2_ready, s1_adv, req_acc, rsp_acc;
  logic [BYTE_W-1:0]  rf_a, rf_b, opa, opb, fwd_val, dm_rdata;
  logic [REG_NUM_W-1:0] fa, fb;
  logic               fwd_ok;

  // Pipeline handshake.
  assign s2_ready    = !s2_valid_q || rsp_o.ready;
  assign s1_adv      = s1_valid_q && s2_ready;
  assign req_i.ready = !s1_valid_q || s2_ready;
  assign req_acc     = req_i.valid && req_i.ready;
  assign rsp_acc     = s2_valid_q && rsp_o.ready;

  // Register file, read as a transaction is accepted, written as a result leaves.
  tiie_regfile #(
    .REG_COUNT (REG_COUNT)
  ) u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (req_acc),
    .rd_num_a_i  (req_i.instr_word[7:4]),
    .rd_num_b_i  (opb_field(req_i.instr_word)),
    .wr_en_i     (rsp_acc && s2_q.rf_we),
    .wr_num_i    (s2_q.rf_waddr),
    .wr_data_i   (fwd_val),
    .rd_data_a_o (rf_a),
    .rd_data_b_o (rf_b)
  );

  // Forward the pending write of the result stage to the execute stage.
  assign fa      = s1_q.instr[7:4];
  assign fb      = opb_field(s1_q.instr);
  assign fwd_val = s2_q.is_load ? dm_rdata : s2_q.rf_wdata;
  assign fwd_ok  = s2_valid_q && s2_q.rf_we;
  assign opa     = (fwd_ok && (s2_q.rf_waddr == fa)) ? fwd_val : rf_a;
  assign opb     = (fwd_ok && (s2_q.rf_waddr == fb)) ? fwd_val : rf_b;

  tiie_exec #(
    .REG_COUNT (REG_COUNT),
    .MEM_BYTES (MEM_BYTES),
    .PC_BITS   (PC_BITS)
  ) u_exec (
    .s1_i   (s1_q),
    .opa_i  (opa),
    .opb_i  (opb),
    .pc_i   (pc_q),
    .halt_i (halt_q),
    .res_o  (exe_res),
    .pc_o   (pc_d),
    .halt_o (halt_d)
  );

  // Data memory, read as an item enters the result stage, written as it leaves.
  tiie_ram #(
    .DATA_W (BYTE_W),
    .DEPTH  (MEM_BYTES)
  ) u_dmem (
    .clk_i   (clk_i),
    .we_i    (rsp_acc && s2_q.dm_we),
    .waddr_i (s2_q.dm_addr[MA_W-1:0]),
    .wdata_i (s2_q.dm_wdata),
    .re_i    (s1_adv),
    .raddr_i (exe_res.dm_addr[MA_W-1:0]),
    .rdata_o (dm_rdata)
  );

  // Control state: stage valid flags, program counter and halt flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      pc_q       <= '0;
      halt_q     <= 1'b0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s1_adv) begin
        pc_q   <= pc_d;
        halt_q <= halt_d;
      end
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      s1_q.req_type <= req_i.req_type;
      s1_q.instr    <= req_i.instr_word;
      s1_q.paddr    <= req_i.preload_addr;
      s1_q.pval     <= req_i.preload_value;
    end
    if (s1_adv) begin
      s2_q <= exe_res;
    end
  end

  // Result transaction; loads take their byte from the data memory.
  assign rsp_o.valid        = s2_valid_q;
  assign rsp_o.next_pc      = s2_q.next_pc;
  assign rsp_o.branch_taken = s2_q.branch_taken;
  assign rsp_o.halted       = s2_q.halted;
  assign rsp_o.illegal_op   = s2_q.illegal_op;
  assign rsp_o.instr_class  = s2_q.instr_class;
  assign rsp_o.reg_write    = s2_q.reg_write;
  assign rsp_o.reg_number   = s2_q.reg_number;
  assign rsp_o.reg_value    = (s2_q.is_load && s2_q.reg_write) ? dm_rdata : s2_q.reg_value;
  assign rsp_o.mem_write    = s2_q.mem_write;
  assign rsp_o.mem_address  = s2_q.mem_address;
  assign rsp_o.mem_value    = s2_q.is_load ? dm_rdata : s2_q.mem_value;

  // Once halted, the machine stays halted.
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt flag cleared without reset");

  // A halted machine never moves its program counter.
  a_halt_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && halt_q) |=> (pc_q == $past(pc_q)))
    else $error("program counter moved while halted");

  // An illegal opcode writes neither a register nor memory.
  a_illegal_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && s2_q.illegal_op) |-> (!s2_q.rf_we && !s2_q.dm_we))
    else $error("illegal opcode caused a state write");

  // No single transaction writes both the register file and the data memory.
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> !(s2_q.rf_we && s2_q.dm_we))
    else $error("register and memory write in one transaction");

endmodule
